FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the odometer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define OTA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition at one edge that implies another at the same edge.
`define OTA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition at one edge that implies another at the next edge.
`define OTA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ota_pkg.sv
// Types and constants of the odometer and trip meter block.
package ota_pkg;

	localparam int PulseW = 16;
	localparam int FracW  = 8;
	localparam int CountW = 32;
	localparam int ModeW  = 3;
	localparam int CfgIdxW = 3;

	// Item mode codes.
	localparam logic [ModeW-1:0] MODE_PULSES     = 3'd0;
	localparam logic [ModeW-1:0] MODE_ODO        = 3'd1;
	localparam logic [ModeW-1:0] MODE_ODO_FRAC   = 3'd2;
	localparam logic [ModeW-1:0] MODE_TRIPA      = 3'd3;
	localparam logic [ModeW-1:0] MODE_TRIPA_FRAC = 3'd4;
	localparam logic [ModeW-1:0] MODE_TRIPB      = 3'd5;
	localparam logic [ModeW-1:0] MODE_TRIPB_FRAC = 3'd6;
	localparam logic [ModeW-1:0] MODE_SAVE       = 3'd7;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_PULSES_PER_STEP = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_FRACTION_LIMIT  = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_ODO_MAX         = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_TRIPA_MAX       = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_TRIPB_MAX       = 3'd4;

	// Register values after reset.
	localparam logic [PulseW-1:0] RST_PULSES_PER_STEP = 16'd100;
	localparam logic [FracW-1:0]  RST_FRACTION_LIMIT  = 8'd9;
	localparam logic [CountW-1:0] RST_ODO_MAX         = 32'd999999;
	localparam logic [CountW-1:0] RST_TRIP_MAX        = 32'd9999;

	typedef struct packed {
		logic [ModeW-1:0]  mode;
		logic [PulseW-1:0] pulses;
		logic [CountW-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [CountW-1:0] odo_whole;
		logic [FracW-1:0]  odo_frac;
		logic [CountW-1:0] tripa_whole;
		logic [FracW-1:0]  tripa_frac;
		logic [CountW-1:0] tripb_whole;
		logic [FracW-1:0]  tripb_frac;
		logic              save_request;
		logic              tripa_wrapped;
		logic              tripb_wrapped;
	} out_item_t;

endpackage

FILE: hw/rtl/ota_meter.sv
// One meter: fraction digit that carries into a whole count.
module ota_meter (
	input  logic                       step,
	input  logic [ota_pkg::FracW-1:0]  frac,
	input  logic [ota_pkg::CountW-1:0] count,
	input  logic [ota_pkg::FracW-1:0]  fraction_limit,
	input  logic [ota_pkg::CountW-1:0] count_max,
	output logic [ota_pkg::FracW-1:0]  frac_next,
	output logic [ota_pkg::CountW-1:0] count_next,
	output logic                       carry,
	output logic                       wrapped
);
	import ota_pkg::*;

	logic [FracW-1:0]  frac_inc;
	logic [CountW-1:0] count_inc;
	logic              frac_over;

	assign frac_inc  = frac + FracW'(1);
	assign count_inc = count + CountW'(1);
	assign frac_over = frac_inc > fraction_limit;
	assign carry     = step && frac_over;
	// The trip meters return to zero once the count passes its maximum.
	assign wrapped   = carry && (count_inc > count_max);

	always_comb begin
		frac_next  = frac;
		count_next = count;
		if (step) begin
			frac_next = frac_over ? '0 : frac_inc;
		end
		if (carry) begin
			count_next = wrapped ? '0 : count_inc;
		end
	end

endmodule

FILE: hw/rtl/odometer_trip_accumulator.sv
// Pulse accumulator driving an odometer and two trip meters, one item per clock when not stalled.
// The block accepts one item per clock cycle unless stalled and returns exactly one result item for
// each: the item is captured in an input register, and the accumulator, fraction and count update
// is done in one pass into the state and result registers. The state feedback closes through the
// state registers alone, so items may follow each other without gaps while the output is not
// stalled. A result waiting on a stalled output does not block the next item from entering the
// input register. Configuration writes are always ready and take effect at once.
`include "assert_macros.svh"

module odometer_trip_accumulator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  ota_pkg::in_item_t             item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output ota_pkg::out_item_t            result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ota_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [ota_pkg::CountW-1:0]    cfg_data
);
	import ota_pkg::*;

	// Configuration registers.
	logic [PulseW-1:0] pulses_per_step_q;
	logic [FracW-1:0]  fraction_limit_q;
	logic [CountW-1:0] odo_max_q;
	logic [CountW-1:0] tripa_max_q;
	logic [CountW-1:0] tripb_max_q;

	// Meter state.
	logic [PulseW-1:0] pulse_accum_q;
	logic [CountW-1:0] odo_count_q;
	logic [FracW-1:0]  odo_frac_q;
	logic [CountW-1:0] tripa_count_q;
	logic [FracW-1:0]  tripa_frac_q;
	logic [CountW-1:0] tripb_count_q;
	logic [FracW-1:0]  tripb_frac_q;
	logic              save_flag_q;

	// Input register and result register.
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_q;
	logic      result_valid_q;

	logic              accept;
	logic              advance;
	logic [PulseW-1:0] accum_sum;
	logic              step;
	logic              is_pulses;

	logic [FracW-1:0]  odo_frac_step;
	logic [CountW-1:0] odo_count_step;
	logic              odo_carry;
	logic              odo_wrap_unused;
	logic [FracW-1:0]  tripa_frac_step;
	logic [CountW-1:0] tripa_count_step;
	logic              tripa_carry;
	logic              tripa_wrap;
	logic [FracW-1:0]  tripb_frac_step;
	logic [CountW-1:0] tripb_count_step;
	logic              tripb_carry;
	logic              tripb_wrap;

	logic [PulseW-1:0] accum_d;
	logic [CountW-1:0] odo_count_d;
	logic [FracW-1:0]  odo_frac_d;
	logic [CountW-1:0] tripa_count_d;
	logic [FracW-1:0]  tripa_frac_d;
	logic [CountW-1:0] tripb_count_d;
	logic [FracW-1:0]  tripb_frac_d;
	logic              save_d;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	assign is_pulses = item_s1.mode == MODE_PULSES;
	assign accum_sum = pulse_accum_q + item_s1.pulses;
	assign step      = is_pulses && (accum_sum > pulses_per_step_q);

	ota_meter u_odo (
		.step           (step),
		.frac           (odo_frac_q),
		.count          (odo_count_q),
		.fraction_limit (fraction_limit_q),
		.count_max      ({CountW{1'b1}}),
		.frac_next      (odo_frac_step),
		.count_next     (odo_count_step),
		.carry          (odo_carry),
		.wrapped        (odo_wrap_unused)
	);

	ota_meter u_tripa (
		.step           (step),
		.frac           (tripa_frac_q),
		.count          (tripa_count_q),
		.fraction_limit (fraction_limit_q),
		.count_max      (tripa_max_q),
		.frac_next      (tripa_frac_step),
		.count_next     (tripa_count_step),
		.carry          (tripa_carry),
		.wrapped        (tripa_wrap)
	);

	ota_meter u_tripb (
		.step           (step),
		.frac           (tripb_frac_q),
		.count          (tripb_count_q),
		.fraction_limit (fraction_limit_q),
		.count_max      (tripb_max_q),
		.frac_next      (tripb_frac_step),
		.count_next     (tripb_count_step),
		.carry          (tripb_carry),
		.wrapped        (tripb_wrap)
	);

	always_comb begin
		accum_d       = pulse_accum_q;
		odo_count_d   = odo_count_q;
		odo_frac_d    = odo_frac_q;
		tripa_count_d = tripa_count_q;
		tripa_frac_d  = tripa_frac_q;
		tripb_count_d = tripb_count_q;
		tripb_frac_d  = tripb_frac_q;
		save_d        = save_flag_q;
		unique case (item_s1.mode)
			MODE_PULSES: begin
				accum_d       = step ? accum_sum - pulses_per_step_q : accum_sum;
				odo_count_d   = odo_count_step;
				odo_frac_d    = odo_frac_step;
				tripa_count_d = tripa_count_step;
				tripa_frac_d  = tripa_frac_step;
				tripb_count_d = tripb_count_step;
				tripb_frac_d  = tripb_frac_step;
				// A carry asks for a save only while the odometer is within range.
				if (odo_carry && (odo_count_step <= odo_max_q)) begin
					save_d = 1'b1;
				end
			end
			MODE_ODO:        odo_count_d   = item_s1.value;
			MODE_ODO_FRAC:   odo_frac_d    = item_s1.value[FracW-1:0];
			MODE_TRIPA:      tripa_count_d = item_s1.value;
			MODE_TRIPA_FRAC: tripa_frac_d  = item_s1.value[FracW-1:0];
			MODE_TRIPB:      tripb_count_d = item_s1.value;
			MODE_TRIPB_FRAC: tripb_frac_d  = item_s1.value[FracW-1:0];
			default:         save_d        = item_s1.value[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulses_per_step_q <= RST_PULSES_PER_STEP;
			fraction_limit_q  <= RST_FRACTION_LIMIT;
			odo_max_q         <= RST_ODO_MAX;
			tripa_max_q       <= RST_TRIP_MAX;
			tripb_max_q       <= RST_TRIP_MAX;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PULSES_PER_STEP: pulses_per_step_q <= cfg_data[PulseW-1:0];
				CFG_FRACTION_LIMIT:  fraction_limit_q  <= cfg_data[FracW-1:0];
				CFG_ODO_MAX:         odo_max_q         <= cfg_data;
				CFG_TRIPA_MAX:       tripa_max_q       <= cfg_data;
				CFG_TRIPB_MAX:       tripb_max_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_accum_q  <= '0;
			odo_count_q    <= '0;
			odo_frac_q     <= '0;
			tripa_count_q  <= '0;
			tripa_frac_q   <= '0;
			tripb_count_q  <= '0;
			tripb_frac_q   <= '0;
			save_flag_q    <= 1'b0;
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
				pulse_accum_q  <= accum_d;
				odo_count_q    <= odo_count_d;
				odo_frac_q     <= odo_frac_d;
				tripa_count_q  <= tripa_count_d;
				tripa_frac_q   <= tripa_frac_d;
				tripb_count_q  <= tripb_count_d;
				tripb_frac_q   <= tripb_frac_d;
				save_flag_q    <= save_d;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q.odo_whole     <= odo_count_d;
			result_q.odo_frac      <= odo_frac_d;
			result_q.tripa_whole   <= tripa_count_d;
			result_q.tripa_frac    <= tripa_frac_d;
			result_q.tripb_whole   <= tripb_count_d;
			result_q.tripb_frac    <= tripb_frac_d;
			result_q.save_request  <= save_d;
			result_q.tripa_wrapped <= is_pulses && tripa_wrap;
			result_q.tripb_wrapped <= is_pulses && tripb_wrap;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`OTA_ASSERT_IMP(a_tripa_wrap_zero, result_valid && result.tripa_wrapped, result.tripa_whole == '0 && result.tripa_frac == '0, "trip A wrapped but not at zero")
	`OTA_ASSERT_IMP(a_tripb_wrap_zero, result_valid && result.tripb_wrapped, result.tripb_whole == '0 && result.tripb_frac == '0, "trip B wrapped but not at zero")
	`OTA_ASSERT_IMP(a_stall_only_full, item_stall, valid_s1 && result_valid && result_stall, "input stalled while a slot is free")
	`OTA_ASSERT_NEXT(a_held_result, result_valid && result_stall, result_valid && $stable(result), "stalled result lost or changed")

endmodule

FILE: sim/odometer_reading_checker.sv
// Checker that predicts the odometer and trip readings and compares every result item.
module odometer_reading_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_stall,
	input  ota_pkg::in_item_t            item,
	input  logic                         result_valid,
	input  logic                         result_stall,
	input  ota_pkg::out_item_t           result,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [ota_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [ota_pkg::CountW-1:0]   cfg_data,
	output int                           pending,
	output int                           errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import ota_pkg::*;

	// Settings as the block should hold them.
	logic [PulseW-1:0] step_pulses;
	logic [FracW-1:0]  frac_lim;
	logic [CountW-1:0] odo_limit;
	logic [CountW-1:0] ta_limit;
	logic [CountW-1:0] tb_limit;

	// Meter state as the block should hold it.
	logic [PulseW-1:0] accum;
	logic [CountW-1:0] odo_cnt;
	logic [CountW-1:0] ta_cnt;
	logic [CountW-1:0] tb_cnt;
	logic [FracW-1:0]  odo_fr;
	logic [FracW-1:0]  ta_fr;
	logic [FracW-1:0]  tb_fr;
	logic              save_pend;

	out_item_t expected_readings[$];

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic step_fraction(inout logic [FracW-1:0] fr, output logic carry);
		logic [FracW-1:0] f;
		f = fr + 1'b1;
		carry = f > frac_lim;
		fr = carry ? '0 : f;
	endtask

	task automatic step_trip(inout logic [CountW-1:0] cnt, input logic [CountW-1:0] lim,
			output logic wrapped);
		logic [CountW-1:0] c;
		c = cnt + 1'b1;
		wrapped = c > lim;
		cnt = wrapped ? '0 : c;
	endtask

	task automatic predict_reading(input in_item_t it, output out_item_t rd);
		logic carry;
		logic wrap_a;
		logic wrap_b;
		wrap_a = 1'b0;
		wrap_b = 1'b0;
		case (it.mode)
		MODE_PULSES: begin
			accum = accum + it.pulses;
			// At most one step per item, however large the accumulator is.
			if (accum > step_pulses) begin
				accum = accum - step_pulses;
				step_fraction(odo_fr, carry);
				if (carry) begin
					odo_cnt = odo_cnt + 1'b1;
					if (odo_cnt <= odo_limit)
						save_pend = 1'b1;
				end
				step_fraction(ta_fr, carry);
				if (carry)
					step_trip(ta_cnt, ta_limit, wrap_a);
				step_fraction(tb_fr, carry);
				if (carry)
					step_trip(tb_cnt, tb_limit, wrap_b);
			end
		end
		MODE_ODO:        odo_cnt = it.value;
		MODE_ODO_FRAC:   odo_fr = it.value[FracW-1:0];
		MODE_TRIPA:      ta_cnt = it.value;
		MODE_TRIPA_FRAC: ta_fr = it.value[FracW-1:0];
		MODE_TRIPB:      tb_cnt = it.value;
		MODE_TRIPB_FRAC: tb_fr = it.value[FracW-1:0];
		default:         save_pend = it.value[0];
		endcase
		rd.odo_whole     = odo_cnt;
		rd.odo_frac      = odo_fr;
		rd.tripa_whole   = ta_cnt;
		rd.tripa_frac    = ta_fr;
		rd.tripb_whole   = tb_cnt;
		rd.tripb_frac    = tb_fr;
		rd.save_request  = save_pend;
		rd.tripa_wrapped = wrap_a;
		rd.tripb_wrapped = wrap_b;
	endtask

	task automatic compare_field(input string name, input logic [CountW-1:0] got,
			input logic [CountW-1:0] want);
		if (got !== want)
			report_error($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic check_reading(input out_item_t got, input out_item_t want);
		compare_field("odo_whole", got.odo_whole, want.odo_whole);
		compare_field("odo_frac", CountW'(got.odo_frac), CountW'(want.odo_frac));
		compare_field("tripa_whole", got.tripa_whole, want.tripa_whole);
		compare_field("tripa_frac", CountW'(got.tripa_frac), CountW'(want.tripa_frac));
		compare_field("tripb_whole", got.tripb_whole, want.tripb_whole);
		compare_field("tripb_frac", CountW'(got.tripb_frac), CountW'(want.tripb_frac));
		compare_field("save_request", CountW'(got.save_request),
			CountW'(want.save_request));
		compare_field("tripa_wrapped", CountW'(got.tripa_wrapped),
			CountW'(want.tripa_wrapped));
		compare_field("tripb_wrapped", CountW'(got.tripb_wrapped),
			CountW'(want.tripb_wrapped));
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t rd;
		if (!arst_n) begin
			step_pulses = RST_PULSES_PER_STEP;
			frac_lim = RST_FRACTION_LIMIT;
			odo_limit = RST_ODO_MAX;
			ta_limit = RST_TRIP_MAX;
			tb_limit = RST_TRIP_MAX;
			accum = '0;
			odo_cnt = '0;
			ta_cnt = '0;
			tb_cnt = '0;
			odo_fr = '0;
			ta_fr = '0;
			tb_fr = '0;
			save_pend = 1'b0;
			expected_readings.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_PULSES_PER_STEP: step_pulses = cfg_data[PulseW-1:0];
				CFG_FRACTION_LIMIT:  frac_lim = cfg_data[FracW-1:0];
				CFG_ODO_MAX:         odo_limit = cfg_data;
				CFG_TRIPA_MAX:       ta_limit = cfg_data;
				CFG_TRIPB_MAX:       tb_limit = cfg_data;
				default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (expected_readings.size() == 0)
					report_error("result item with no item waiting for it");
				else
					check_reading(result, expected_readings.pop_front());
			end
			if (item_valid && !item_stall) begin
				predict_reading(item, rd);
				expected_readings.push_back(rd);
			end
		end
		pending = expected_readings.size();
	end

endmodule

FILE: sim/tb.sv
// Testbench top for the odometer and trip meter block: stimulus, settings and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ota_pkg::*;

	localparam int HoldCycles = 400;
	// An index past the last register; writes to it must change nothing.
	localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	in_item_t           item;
	logic               result_valid;
	logic               result_stall;
	out_item_t          result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CountW-1:0]  cfg_data;
	int                 pending;
	int                 errors;

	int  send_idle_pct;
	int  stall_pct;
	logic long_hold;

	// Current settings, used to aim random items at the interesting boundaries.
	logic [PulseW-1:0] cur_step;
	logic [FracW-1:0]  cur_frac;
	logic [CountW-1:0] cur_odo_max;
	logic [CountW-1:0] cur_ta_max;
	logic [CountW-1:0] cur_tb_max;

	odometer_trip_accumulator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	odometer_reading_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.errors       (errors)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Output side: random stalls, or one long hold-off when asked for.
	always begin
		@(posedge clk);
		if (long_hold) begin
			result_stall <= 1'b1;
			repeat (HoldCycles) @(posedge clk);
			long_hold = 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic in_item_t make_item(input logic [ModeW-1:0] m,
			input logic [PulseW-1:0] p, input logic [CountW-1:0] v);
		in_item_t it;
		it.mode = m;
		it.pulses = p;
		it.value = v;
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		logic [CountW-1:0] lim;
		it.mode = MODE_PULSES;
		it.pulses = PulseW'($urandom);
		it.value = $urandom;
		if ($urandom_range(99) < 72) begin
			case ($urandom_range(5))
			0: ;
			1: it.pulses = '0;
			default: it.pulses = PulseW'($urandom_range(cur_step * 2 + 2));
			endcase
		end else begin
			it.mode = ModeW'($urandom_range(MODE_SAVE, MODE_ODO));
			case (it.mode)
			MODE_ODO:   lim = cur_odo_max;
			MODE_TRIPA: lim = cur_ta_max;
			default:    lim = cur_tb_max;
			endcase
			if ($urandom_range(3) == 0)
				lim = '1;
			// Most presets land just below a limit so that carries and wraps follow soon.
			if ($urandom_range(2) != 0) begin
				if (it.mode == MODE_ODO_FRAC || it.mode == MODE_TRIPA_FRAC ||
						it.mode == MODE_TRIPB_FRAC)
					it.value[FracW-1:0] = FracW'(cur_frac - $urandom_range(1));
				else if (it.mode != MODE_SAVE)
					it.value = lim - $urandom_range(2);
			end
		end
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic send_random(input int n);
		repeat (n) send_item(random_item());
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic start_phase(input logic [PulseW-1:0] step, input logic [FracW-1:0] frac,
			input logic [CountW-1:0] odo_max, input logic [CountW-1:0] ta_max,
			input logic [CountW-1:0] tb_max, input int idle, input int stall);
		wait_drained();
		cur_step = step;
		cur_frac = frac;
		cur_odo_max = odo_max;
		cur_ta_max = ta_max;
		cur_tb_max = tb_max;
		write_reg(CFG_PULSES_PER_STEP, CountW'(step));
		write_reg(CFG_FRACTION_LIMIT, CountW'(frac));
		write_reg(CFG_ODO_MAX, odo_max);
		write_reg(CFG_TRIPA_MAX, ta_max);
		write_reg(CFG_TRIPB_MAX, tb_max);
		if ($urandom_range(1) == 0)
			write_reg(CfgIdxSpare, $urandom);
		cfg_valid <= 1'b0;
		send_idle_pct = idle;
		stall_pct = stall;
	endtask

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		result_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		send_idle_pct = 0;
		stall_pct = 0;
		long_hold = 1'b0;
		cur_step = RST_PULSES_PER_STEP;
		cur_frac = RST_FRACTION_LIMIT;
		cur_odo_max = RST_ODO_MAX;
		cur_ta_max = RST_TRIP_MAX;
		cur_tb_max = RST_TRIP_MAX;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset settings.
		send_item(make_item(MODE_PULSES, 16'd0, 32'hFFFF_FFFF));
		send_item(make_item(MODE_PULSES, 16'd100, 32'd0));
		send_item(make_item(MODE_PULSES, 16'd1, 32'd0));
		// The accumulator wraps back to zero, then holds a huge count.
		send_item(make_item(MODE_PULSES, 16'hFFFF, 32'd0));
		send_item(make_item(MODE_PULSES, 16'hFFFF, 32'd0));
		send_item(make_item(MODE_ODO, 16'hFFFF, 32'hFFFF_FFFF));
		send_item(make_item(MODE_ODO_FRAC, 16'h5A5A, 32'hABCD_EFC8));
		send_item(make_item(MODE_SAVE, 16'd0, 32'hFFFF_FFFE));
		// Fraction above the limit carries; the odometer wraps to zero and asks for a save.
		send_item(make_item(MODE_PULSES, 16'd0, 32'd0));
		send_item(make_item(MODE_TRIPA, 16'd0, 32'd9999));
		send_item(make_item(MODE_TRIPA_FRAC, 16'd0, 32'hFFFF_FF09));
		send_item(make_item(MODE_TRIPB, 16'd0, 32'hFFFF_FFFF));
		send_item(make_item(MODE_TRIPB_FRAC, 16'd0, 32'd9));
		send_item(make_item(MODE_PULSES, 16'd0, 32'd0));
		send_item(make_item(MODE_ODO, 16'd0, 32'd999999));
		send_item(make_item(MODE_ODO_FRAC, 16'd0, 32'd9));
		send_item(make_item(MODE_SAVE, 16'd0, 32'd0));
		// A carry past the odometer maximum must not request a save.
		send_item(make_item(MODE_PULSES, 16'd0, 32'd0));
		send_item(make_item(MODE_SAVE, 16'd0, 32'd1));
		send_item(make_item(MODE_ODO_FRAC, 16'd0, 32'd255));
		send_item(make_item(MODE_PULSES, 16'h8000, 32'd0));
		send_item(make_item(MODE_TRIPB_FRAC, 16'hAAAA, 32'h5555_5555));
		send_item(make_item(MODE_PULSES, 16'd0, 32'd0));
		send_random(240);

		// Zero step size and zero limits: nonzero accumulators step; fractions below 255 carry.
		start_phase(16'd0, 8'd0, 32'd0, 32'd0, 32'd0, 57, 0);
		send_random(240);

		// Top settings: no step can ever happen, and a 255 fraction limit never carries.
		start_phase(16'hFFFF, 8'hFF, '1, '1, '1, 0, 57);
		send_random(150);

		start_phase(16'd1, 8'd254, 32'd1, 32'd2, 32'd3, 10, 10);
		send_random(240);

		start_phase(PulseW'($urandom_range(300, 1)), FracW'($urandom_range(4, 1)),
			$urandom_range(50), $urandom_range(50), $urandom_range(50), 57, 57);
		send_random(150);
		// Hold the output off while items keep coming, so the block fills and stalls.
		long_hold = 1'b1;
		send_random(100);
		wait_drained();
		send_random(50);

		start_phase(PulseW'($urandom), FracW'($urandom_range(254, 1)), $urandom, $urandom,
			$urandom, 0, 0);
		send_random(250);

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: errors");
		$finish;
	end

endmodule
